/* rtl/efrr_pkg.sv */
// ----------------------------------------------------------------------------
// efrr_pkg: shared definitions for the event flag round-robin selector
// Command codes, register indexes, widths and the lowest-set-bit encoder.
// ----------------------------------------------------------------------------
package efrr_pkg;

	localparam int unsigned MAX_FLAGS = 16;
	localparam int unsigned IDX_W     = $clog2(MAX_FLAGS);
	localparam int unsigned CNT_W     = $clog2(MAX_FLAGS + 1);
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [MAX_FLAGS-1:0] flag_vec_t;
	typedef logic [IDX_W-1:0]     flag_idx_t;
	typedef logic [CNT_W-1:0]     flag_cnt_t;

	typedef enum logic [2:0] {
		CMD_SET      = 3'd0,
		CMD_CLEAR    = 3'd1,
		CMD_PEEK_ANY = 3'd2,
		CMD_TAKE_ANY = 3'd3,
		CMD_TAKE_ALL = 3'd4,
		CMD_READ     = 3'd5
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_FLAGS    = 2'd0,
		REG_ZERO_FIRST      = 2'd1,
		REG_AUTO_CLEAR_MASK = 2'd2
	} reg_idx_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic flag_idx_t lowest_set(input flag_vec_t vec);
		flag_idx_t res;
		res = '0;
		for (int i = MAX_FLAGS - 1; i >= 0; i--) begin
			if (vec[i]) begin
				res = flag_idx_t'(i);
			end
		end
		return res;
	endfunction

endpackage

/* rtl/event_flag_round_robin_select.sv */
// ----------------------------------------------------------------------------
// event_flag_round_robin_select: event flag bank with round-robin selection
// Sets, clears and reads single flags; peek and take select set flags round
// robin from a stored pointer; take-all checks all active flags and clears the auto-clear ones.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid / in_stall    | command, flag_index
//  out      | out_valid / out_stall  | found, granted_index, flag_value,
//           |                        | all_set
//  cfg      | cfg_we (no wait)       | cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_stall is low. A command
// lands in the input register when accepted, and its result is loaded into
// the result register as that register advances. The rotate, priority
// encode and flag update for one command all sit between these two
// registers, which keeps a new command per cycle unless out_stall holds.
// Reset clears the flags and the rotate pointer and loads the register
// defaults (16 active flags, zero-first off, no auto-clear).
// When out_stall holds a pending result, the input register keeps its
// command and in_stall rises once that register is occupied.
//
module event_flag_round_robin_select (
	input  logic                              clk,
	input  logic                              arst_n,
	// Command channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        command,
	input  logic [efrr_pkg::IDX_W-1:0]        flag_index,
	// Result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [efrr_pkg::IDX_W-1:0]        granted_index,
	output logic                              flag_value,
	output logic                              all_set,
	// Configuration write port
	input  logic                              cfg_we,
	input  logic [efrr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [efrr_pkg::CFG_W-1:0]        cfg_data
);

	// Configuration registers.
	logic [4:0]            active_flags_q;
	logic                  zero_first_q;
	efrr_pkg::flag_vec_t   auto_clear_q;

	// Architectural state.
	efrr_pkg::flag_vec_t   flags_q;
	efrr_pkg::flag_idx_t   ptr_q;

	// Input register (stage 1).
	logic                  valid_s1;
	logic [2:0]            cmd_s1;
	efrr_pkg::flag_idx_t   idx_s1;

	// Result register (stage 2).
	logic                  valid_s2;
	logic                  found_s2;
	efrr_pkg::flag_idx_t   grant_s2;
	logic                  value_s2;
	logic                  all_set_s2;

	logic                  in_accept;
	logic                  adv_s1;
	logic                  fire_s1;

	// Selection datapath.
	efrr_pkg::flag_cnt_t   n_act;
	efrr_pkg::flag_cnt_t   rot_len;
	efrr_pkg::flag_idx_t   start;
	efrr_pkg::flag_vec_t   shifted;
	efrr_pkg::flag_vec_t   in_len;
	efrr_pkg::flag_vec_t   cand;
	efrr_pkg::flag_vec_t   cand_hi;
	efrr_pkg::flag_idx_t   pos;
	efrr_pkg::flag_cnt_t   pos_inc;
	efrr_pkg::flag_vec_t   act_mask;
	logic                  sel_found;
	efrr_pkg::flag_idx_t   sel_idx;
	logic                  sel_moves_ptr;
	efrr_pkg::flag_idx_t   sel_next_ptr;

	// Next-state and result values.
	efrr_pkg::flag_vec_t   flags_d;
	efrr_pkg::flag_idx_t   ptr_d;
	logic                  found_d;
	efrr_pkg::flag_idx_t   grant_d;
	logic                  value_d;
	logic                  all_set_d;

	// The result register moves on when it is empty or being taken; the
	// input register follows it.
	assign adv_s1    = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;
	assign fire_s1   = valid_s1 && adv_s1;

	// Active count is clamped into 1..MAX_FLAGS. In zero-first mode flag 0
	// leaves the rotation, which then covers flags 1 to N-1.
	always_comb begin
		if (active_flags_q == 5'd0) begin
			n_act = efrr_pkg::flag_cnt_t'(1);
		end else if (active_flags_q > 5'(efrr_pkg::MAX_FLAGS)) begin
			n_act = efrr_pkg::flag_cnt_t'(efrr_pkg::MAX_FLAGS);
		end else begin
			n_act = efrr_pkg::flag_cnt_t'(active_flags_q);
		end
		rot_len  = n_act - efrr_pkg::flag_cnt_t'(zero_first_q);
		act_mask = ~({efrr_pkg::MAX_FLAGS{1'b1}} << n_act);
	end

	always_comb begin
		// A pointer left outside the current rotation restarts at offset 0.
		if (efrr_pkg::flag_cnt_t'(ptr_q) < rot_len) begin
			start = ptr_q;
		end else begin
			start = '0;
		end
		shifted = zero_first_q ? (flags_q >> 1) : flags_q;
		in_len  = ~({efrr_pkg::MAX_FLAGS{1'b1}} << rot_len);
		cand    = shifted & in_len;
		cand_hi = cand & ({efrr_pkg::MAX_FLAGS{1'b1}} << start);
		// First candidate at or after the start offset, else wrap around.
		if (|cand_hi) begin
			pos = efrr_pkg::lowest_set(cand_hi);
		end else begin
			pos = efrr_pkg::lowest_set(cand);
		end
		pos_inc = efrr_pkg::flag_cnt_t'(pos) + efrr_pkg::flag_cnt_t'(1);
		if (pos_inc >= rot_len) begin
			sel_next_ptr = '0;
		end else begin
			sel_next_ptr = pos_inc[efrr_pkg::IDX_W-1:0];
		end

		if (zero_first_q && flags_q[0]) begin
			// Fixed-priority flag 0 wins and the rotation stays where it is.
			sel_found     = 1'b1;
			sel_idx       = '0;
			sel_moves_ptr = 1'b0;
		end else begin
			sel_found     = |cand;
			sel_idx       = pos + efrr_pkg::flag_idx_t'(zero_first_q);
			sel_moves_ptr = |cand;
		end
	end

	// Command decode and state update.
	always_comb begin
		flags_d   = flags_q;
		ptr_d     = ptr_q;
		found_d   = 1'b0;
		grant_d   = '0;
		value_d   = 1'b0;
		all_set_d = 1'b0;
		unique case (cmd_s1)
			efrr_pkg::CMD_SET: begin
				flags_d[idx_s1] = 1'b1;
			end
			efrr_pkg::CMD_CLEAR: begin
				flags_d[idx_s1] = 1'b0;
			end
			efrr_pkg::CMD_PEEK_ANY, efrr_pkg::CMD_TAKE_ANY: begin
				if (sel_found) begin
					found_d = 1'b1;
					grant_d = sel_idx;
					if (sel_moves_ptr) begin
						ptr_d = sel_next_ptr;
					end
					if (cmd_s1 == efrr_pkg::CMD_TAKE_ANY && auto_clear_q[sel_idx]) begin
						flags_d[sel_idx] = 1'b0;
					end
				end
			end
			efrr_pkg::CMD_TAKE_ALL: begin
				all_set_d = ((flags_q & act_mask) == act_mask);
				flags_d   = flags_q & ~(act_mask & auto_clear_q);
			end
			efrr_pkg::CMD_READ: begin
				value_d = flags_q[idx_s1];
			end
			default: begin
				// Unused codes leave the state alone and return zeros.
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_flags_q <= 5'(efrr_pkg::MAX_FLAGS);
			zero_first_q   <= 1'b0;
			auto_clear_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				efrr_pkg::REG_ACTIVE_FLAGS:    active_flags_q <= cfg_data[4:0];
				efrr_pkg::REG_ZERO_FIRST:      zero_first_q   <= cfg_data[0];
				efrr_pkg::REG_AUTO_CLEAR_MASK: auto_clear_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Flag bank and rotate pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			ptr_q   <= '0;
		end else if (fire_s1) begin
			flags_q <= flags_d;
			ptr_q   <= ptr_d;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1 <= command;
			idx_s1 <= flag_index;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			found_s2   <= found_d;
			grant_s2   <= grant_d;
			value_s2   <= value_d;
			all_set_s2 <= all_set_d;
		end
	end

	assign out_valid     = valid_s2;
	assign found         = found_s2;
	assign granted_index = grant_s2;
	assign flag_value    = value_s2;
	assign all_set       = all_set_s2;

`ifndef SYNTH
	// A result carries at most one kind of report.
	a_one_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({found, flag_value, all_set}) <= 1)
		else $error("result reports more than one kind of outcome");

	// Without a grant the granted index reads as zero.
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (granted_index == '0))
		else $error("granted index nonzero without a grant");

	// A take of an auto-clear flag leaves that flag cleared.
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && cmd_s1 == efrr_pkg::CMD_TAKE_ANY && sel_found
			&& auto_clear_q[sel_idx])
		|=> !flags_q[$past(sel_idx)])
		else $error("taken auto-clear flag still set");

	// Fixed-priority grant of flag 0 leaves the rotate pointer in place.
	a_zero_first_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && zero_first_q && flags_q[0]
			&& (cmd_s1 == efrr_pkg::CMD_PEEK_ANY || cmd_s1 == efrr_pkg::CMD_TAKE_ANY))
		|=> $stable(ptr_q))
		else $error("rotate pointer moved on a fixed-priority grant");

	// A stalled result keeps the input register occupied command in place.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(cmd_s1) && $stable(idx_s1)))
		else $error("input register lost a command under stall");
`endif

endmodule
